// ===== rtl/core/pcdm_pkg.sv =====
// pcdm_pkg: shared constants, codes and types of the pedal cadence meter core
// depends on nothing; every rtl/core file but pcdm_ram uses it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package pcdm_pkg;

   // record ring
   localparam int RING_DEPTH = 16;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // field widths
   localparam int TIME_W   = 32;
   localparam int MAG_W    = 8;
   localparam int MINREC_W = 5;
   localparam int RPM_W    = 17;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // edge filter
   localparam logic [TIME_W-1:0] GLITCH_US = TIME_W'(5000);

   // arithmetic widths: sum of high+low over the ring, mean, scaled divisor
   localparam int SUM_W  = TIME_W + 1 + RING_AW;
   localparam int MEAN_W = TIME_W + 1;
   localparam int DEN_W  = MEAN_W + MAG_W;
   localparam int NUM_W  = SUM_W;
   localparam int STEP_W = $clog2(NUM_W + 1);

   // 60e6 us per minute times 16 for four fraction bits
   localparam logic [NUM_W-1:0] RPM_NUM = NUM_W'(960000000);
   localparam logic [NUM_W-1:0] RPM_MAX = NUM_W'((2 ** RPM_W) - 1);

   // register reset values, also used when a register holds zero
   localparam logic [MAG_W-1:0]    MAGNETS_DEFAULT = MAG_W'(12);
   localparam logic [MINREC_W-1:0] MINREC_DEFAULT  = MINREC_W'(2);
   localparam logic [TIME_W-1:0]   WINDOW_DEFAULT  = TIME_W'(1000000);

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAGNET_COUNT = 2'd0,
      CSR_MIN_RECORDS  = 2'd1,
      CSR_WINDOW_US    = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_EDGE  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] high;
      logic [TIME_W-1:0] low;
   } record_type;

   typedef struct packed {
      cmd_kind_type kind;
      record_type   rec;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic [MAG_W-1:0]    magnets;
      logic [MINREC_W-1:0] need;
      logic [TIME_W-1:0]   window;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DECIDE,
      ST_MEAN,
      ST_SCALE,
      ST_RPM,
      ST_REPLY
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/pcdm_ram.sv =====
// pcdm_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module pcdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcdm_div.sv =====
// pcdm_div: restoring divider, one quotient bit per cycle
// depends on pcdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcdm_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pcdm_pkg::NUM_W-1:0]  numer,
   input  wire logic [pcdm_pkg::DEN_W-1:0]  denom,
   output logic                             done,
   output logic      [pcdm_pkg::NUM_W-1:0]  quot
);

   logic [pcdm_pkg::STEP_W-1:0] step_ff, step_in;
   logic [pcdm_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [pcdm_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [pcdm_pkg::DEN_W-1:0]  den_ff, den_in;
   logic                        done_ff, done_in;
   logic [pcdm_pkg::DEN_W:0]    trial;
   logic [pcdm_pkg::DEN_W:0]    diff;
   logic                        fits;

   always_comb begin
      trial   = {rem_ff, num_ff[pcdm_pkg::NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = pcdm_pkg::STEP_W'(pcdm_pkg::NUM_W);
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (step_ff != '0) begin
         // shift in the next numerator bit, quotient bits fill from the bottom
         num_in  = {num_ff[pcdm_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? diff[pcdm_pkg::DEN_W-1:0] : trial[pcdm_pkg::DEN_W-1:0];
         step_in = step_ff - 1'b1;
         done_in = (step_ff == pcdm_pkg::STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pcdm_cmd_queue.sv =====
// pcdm_cmd_queue: short fifo of commands between the front and the back
// depends on pcdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcdm_cmd_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire pcdm_pkg::cmd_type        din,
   input  wire logic                     pop,
   output pcdm_pkg::cmd_type             dout,
   output pcdm_pkg::queue_stat_type      stat
);

   pcdm_pkg::cmd_type            entry_ff [pcdm_pkg::CMDQ_DEPTH];
   logic [pcdm_pkg::CMDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcdm_pkg::CMDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcdm_pkg::CMDQ_CW-1:0] fill_ff, fill_in;
   logic                         do_push;
   logic                         do_pop;

   function automatic logic [pcdm_pkg::CMDQ_AW-1:0] next_ptr(
      input logic [pcdm_pkg::CMDQ_AW-1:0] ptr
   );
      logic [pcdm_pkg::CMDQ_AW-1:0] nxt;
      if (ptr == pcdm_pkg::CMDQ_AW'(pcdm_pkg::CMDQ_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && !stat.empty;
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout       = entry_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == pcdm_pkg::CMDQ_CW'(pcdm_pkg::CMDQ_DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/pcdm_front.sv =====
// pcdm_front: takes input words, filters glitches, times half periods
// and turns edges and queries into commands for the back; depends on pcdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcdm_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   input  wire logic                         req_op,
   input  wire logic [pcdm_pkg::TIME_W-1:0]  req_time_us,
   input  wire logic                         req_pin_level,
   input  wire pcdm_pkg::queue_stat_type     q_stat,
   output logic                              cmd_push,
   output pcdm_pkg::cmd_type                 cmd
);

   logic [pcdm_pkg::TIME_W-1:0] last_edge_ff, last_edge_in;
   logic [pcdm_pkg::TIME_W-1:0] held_low_ff, held_low_in;
   logic [pcdm_pkg::TIME_W-1:0] dt;
   logic                        accept;
   logic                        clean;

   always_comb begin
      accept       = req_push && !q_stat.full;
      dt           = req_time_us - last_edge_ff;
      clean        = (dt >= pcdm_pkg::GLITCH_US);
      last_edge_in = last_edge_ff;
      held_low_in  = held_low_ff;
      cmd_push     = 1'b0;
      cmd.kind     = pcdm_pkg::CMD_QUERY;
      cmd.rec.stamp = req_time_us;
      cmd.rec.high = dt;
      cmd.rec.low  = held_low_ff;
      if (accept) begin
         if (pcdm_pkg::op_type'(req_op) == pcdm_pkg::OP_QUERY) begin
            cmd_push = 1'b1;
         end else begin
            // a glitch still moves the last-edge time
            last_edge_in = req_time_us;
            if (clean) begin
               if (req_pin_level) begin
                  held_low_in = dt;
               end else if (held_low_ff != '0) begin
                  cmd_push = 1'b1;
                  cmd.kind = pcdm_pkg::CMD_PUSH;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         held_low_ff  <= '0;
      end else begin
         last_edge_ff <= last_edge_in;
         held_low_ff  <= held_low_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcdm_back.sv =====
// pcdm_back: record ring, expiry walk with vote and sum, two serial divisions
// and the result register; depends on pcdm_pkg, pcdm_ram and pcdm_div
`timescale 1ns / 1ps
`default_nettype none

module pcdm_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pcdm_pkg::cfg_type            cfg,
   input  wire pcdm_pkg::queue_stat_type     q_stat,
   input  wire pcdm_pkg::cmd_type            cmd,
   output logic                              cmd_pop,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic      [pcdm_pkg::RPM_W-1:0]   rsp_rpm_x16,
   output logic                              rsp_forward,
   output logic                              rsp_cadence_valid
);

   pcdm_pkg::back_state_type      state_ff, state_in;
   logic [pcdm_pkg::RING_AW-1:0]  head_ff, head_in;
   logic [pcdm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [pcdm_pkg::RING_AW-1:0]  oldest_ff, oldest_in;
   logic [pcdm_pkg::CNT_W-1:0]    issue_ff, issue_in;
   logic                          pend_ff, pend_in;
   logic [pcdm_pkg::CNT_W-1:0]    kept_ff, kept_in;
   logic [pcdm_pkg::CNT_W-1:0]    fwd_ff, fwd_in;
   logic [pcdm_pkg::CNT_W-1:0]    bwd_ff, bwd_in;
   logic [pcdm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [pcdm_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [pcdm_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [pcdm_pkg::RPM_W-1:0]    res_rpm_ff, res_rpm_in;
   logic                          res_fwd_ff, res_fwd_in;
   logic                          res_valid_ff, res_valid_in;
   logic                          rsp_full_ff, rsp_full_in;
   logic [pcdm_pkg::RPM_W-1:0]    rsp_rpm_ff, rsp_rpm_in;
   logic                          rsp_fwd_ff, rsp_fwd_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          wr_en;
   logic [pcdm_pkg::RING_AW-1:0]  wr_addr;
   pcdm_pkg::record_type          wr_data;
   logic [pcdm_pkg::RING_AW-1:0]  rd_addr;
   pcdm_pkg::record_type          rd_data;

   logic                          div_start;
   logic [pcdm_pkg::NUM_W-1:0]    div_numer;
   logic [pcdm_pkg::DEN_W-1:0]    div_denom;
   logic                          div_done;
   logic [pcdm_pkg::NUM_W-1:0]    div_quot;

   logic [pcdm_pkg::TIME_W-1:0]   age;
   logic [pcdm_pkg::MEAN_W-1:0]   mean;

   pcdm_ram #(
      .WIDTH ($bits(pcdm_pkg::record_type)),
      .DEPTH (pcdm_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pcdm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      kept_in      = kept_ff;
      fwd_in       = fwd_ff;
      bwd_in       = bwd_ff;
      sum_in       = sum_ff;
      now_in       = now_ff;
      den_in       = den_ff;
      res_rpm_in   = res_rpm_ff;
      res_fwd_in   = res_fwd_ff;
      res_valid_in = res_valid_ff;
      rsp_full_in  = rsp_full_ff && !rsp_pop;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_fwd_in   = rsp_fwd_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = cmd.rec;
      rd_addr      = oldest_ff + issue_ff[pcdm_pkg::RING_AW-1:0];
      div_start    = 1'b0;
      div_numer    = sum_ff;
      div_denom    = pcdm_pkg::DEN_W'(kept_ff);
      age          = now_ff - rd_data.stamp;
      mean         = div_quot[pcdm_pkg::MEAN_W-1:0];

      case (state_ff)
         pcdm_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               cmd_pop = 1'b1;
               if (cmd.kind == pcdm_pkg::CMD_PUSH) begin
                  // newest record at head, oldest one drops out when full
                  wr_en   = 1'b1;
                  head_in = head_ff + 1'b1;
                  if (count_ff < pcdm_pkg::CNT_W'(pcdm_pkg::RING_DEPTH)) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  oldest_in = head_ff - count_ff[pcdm_pkg::RING_AW-1:0];
                  issue_in  = '0;
                  kept_in   = '0;
                  fwd_in    = '0;
                  bwd_in    = '0;
                  sum_in    = '0;
                  now_in    = cmd.rec.stamp;
                  state_in  = pcdm_pkg::ST_WALK;
               end
            end
         end

         pcdm_pkg::ST_WALK: begin
            // reads run one ahead of the compare; survivors are written back
            // packed behind the oldest slot, never ahead of the read pointer
            if (issue_ff < count_ff) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff && (age <= cfg.window)) begin
               wr_en   = 1'b1;
               wr_addr = oldest_ff + kept_ff[pcdm_pkg::RING_AW-1:0];
               wr_data = rd_data;
               kept_in = kept_ff + 1'b1;
               sum_in  = sum_ff + pcdm_pkg::SUM_W'(rd_data.high)
                                + pcdm_pkg::SUM_W'(rd_data.low);
               if (rd_data.high > rd_data.low) begin
                  fwd_in = fwd_ff + 1'b1;
               end else begin
                  bwd_in = bwd_ff + 1'b1;
               end
            end
            if ((issue_ff == count_ff) && !pend_ff) begin
               count_in = kept_ff;
               head_in  = oldest_ff + kept_ff[pcdm_pkg::RING_AW-1:0];
               state_in = pcdm_pkg::ST_DECIDE;
            end
         end

         pcdm_pkg::ST_DECIDE: begin
            if ((kept_ff == '0) || (pcdm_pkg::MINREC_W'(kept_ff) < cfg.need)
                || (fwd_ff == bwd_ff)) begin
               res_rpm_in   = '0;
               res_fwd_in   = 1'b0;
               res_valid_in = 1'b0;
               state_in     = pcdm_pkg::ST_REPLY;
            end else begin
               div_start = 1'b1;
               state_in  = pcdm_pkg::ST_MEAN;
            end
         end

         pcdm_pkg::ST_MEAN: begin
            if (div_done) begin
               den_in   = pcdm_pkg::DEN_W'(mean) * pcdm_pkg::DEN_W'(cfg.magnets);
               state_in = pcdm_pkg::ST_SCALE;
            end
         end

         pcdm_pkg::ST_SCALE: begin
            res_fwd_in   = (fwd_ff > bwd_ff);
            res_valid_in = 1'b1;
            if (den_ff == '0) begin
               res_rpm_in = '0;
               state_in   = pcdm_pkg::ST_REPLY;
            end else begin
               div_start = 1'b1;
               div_numer = pcdm_pkg::RPM_NUM;
               div_denom = den_ff;
               state_in  = pcdm_pkg::ST_RPM;
            end
         end

         pcdm_pkg::ST_RPM: begin
            if (div_done) begin
               if (div_quot > pcdm_pkg::RPM_MAX) begin
                  res_rpm_in = pcdm_pkg::RPM_MAX[pcdm_pkg::RPM_W-1:0];
               end else begin
                  res_rpm_in = div_quot[pcdm_pkg::RPM_W-1:0];
               end
               state_in = pcdm_pkg::ST_REPLY;
            end
         end

         pcdm_pkg::ST_REPLY: begin
            if (!rsp_full_ff || rsp_pop) begin
               rsp_full_in  = 1'b1;
               rsp_rpm_in   = res_rpm_ff;
               rsp_fwd_in   = res_fwd_ff;
               rsp_valid_in = res_valid_ff;
               state_in     = pcdm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pcdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pcdm_pkg::ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         oldest_ff   <= '0;
         issue_ff    <= '0;
         pend_ff     <= 1'b0;
         kept_ff     <= '0;
         fwd_ff      <= '0;
         bwd_ff      <= '0;
         rsp_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         oldest_ff   <= oldest_in;
         issue_ff    <= issue_in;
         pend_ff     <= pend_in;
         kept_ff     <= kept_in;
         fwd_ff      <= fwd_in;
         bwd_ff      <= bwd_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      now_ff       <= now_in;
      den_ff       <= den_in;
      res_rpm_ff   <= res_rpm_in;
      res_fwd_ff   <= res_fwd_in;
      res_valid_ff <= res_valid_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_fwd_ff   <= rsp_fwd_in;
      rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_empty         = !rsp_full_ff;
   assign rsp_rpm_x16       = rsp_rpm_ff;
   assign rsp_forward       = rsp_fwd_ff;
   assign rsp_cadence_valid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcdm_pkg::CNT_W'(pcdm_pkg::RING_DEPTH))
      else $error("record count above ring depth");

   a_vote_total: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fwd_ff} + {1'b0, bwd_ff}) == {1'b0, kept_ff})
      else $error("votes do not add up to kept records");

   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcdm_pkg::ST_WALK) |-> (kept_ff <= issue_ff))
      else $error("compaction write ahead of read pointer");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == pcdm_pkg::ST_DECIDE || state_ff == pcdm_pkg::ST_SCALE))
      else $error("divider started outside a divide step");

endmodule

`default_nettype wire

// ===== rtl/core/pedal_cadence_direction_meter_core.sv =====
// pedal_cadence_direction_meter_core: top level with the register port
// depends on pcdm_pkg, pcdm_front, pcdm_cmd_queue and pcdm_back
`timescale 1ns / 1ps
`default_nettype none

// Pedal cadence and direction meter. Each input word is either a sensor edge
// (op 0, pin level after the edge) or a cadence query (op 1), both stamped with
// a free-running microsecond time. Edges closer than 5000 us to the previous
// edge are dropped but still move the last-edge time. A rising edge holds the
// low time; a falling edge, once a low time is held, files a (time, high, low)
// record into a 16-entry ring that keeps the newest records. A query first
// drops records older than window_us (wrap-safe age), then with at least
// min_records left reports rpm_x16 = 960000000 / (mean period * magnet_count),
// saturated at 131071, and forward when most records have high > low. Too few
// records or a tied vote give zeros with cadence_valid low. Registers written
// as zero behave as their reset value; write registers only while idle.
// Timing: the front takes a word every cycle while the two-word command queue
// is not full; the back files an edge from its idle state. A query makes the
// back walk the ring, reading the ring ram once per record, then the shared
// serial divider computes first the mean and then the rpm. The result sits
// in an output register, so the next query can start while the previous
// result waits to be popped.

module pedal_cadence_direction_meter_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input words
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_op,
   input  wire logic [pcdm_pkg::TIME_W-1:0]     req_time_us,
   input  wire logic                            req_pin_level,
   // result words
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic      [pcdm_pkg::RPM_W-1:0]      rsp_rpm_x16,
   output logic                                 rsp_forward,
   output logic                                 rsp_cadence_valid,
   // register writes
   input  wire logic                            csr_write_en,
   input  wire logic [pcdm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pcdm_pkg::CSR_W-1:0]      csr_wdata
);

   logic [pcdm_pkg::MAG_W-1:0]    magnets_ff, magnets_in;
   logic [pcdm_pkg::MINREC_W-1:0] min_rec_ff, min_rec_in;
   logic [pcdm_pkg::TIME_W-1:0]   window_ff, window_in;
   pcdm_pkg::cfg_type             cfg;
   pcdm_pkg::queue_stat_type      q_stat;
   pcdm_pkg::cmd_type             cmd_in_q;
   pcdm_pkg::cmd_type             cmd_out_q;
   logic                          cmd_push;
   logic                          cmd_pop;

   // register writes, unknown indexes ignored
   always_comb begin
      magnets_in = magnets_ff;
      min_rec_in = min_rec_ff;
      window_in  = window_ff;
      if (csr_write_en) begin
         case (pcdm_pkg::csr_index_type'(csr_index))
            pcdm_pkg::CSR_MAGNET_COUNT: magnets_in = csr_wdata[pcdm_pkg::MAG_W-1:0];
            pcdm_pkg::CSR_MIN_RECORDS:  min_rec_in = csr_wdata[pcdm_pkg::MINREC_W-1:0];
            pcdm_pkg::CSR_WINDOW_US:    window_in  = csr_wdata[pcdm_pkg::TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magnets_ff <= pcdm_pkg::MAGNETS_DEFAULT;
         min_rec_ff <= pcdm_pkg::MINREC_DEFAULT;
         window_ff  <= pcdm_pkg::WINDOW_DEFAULT;
      end else begin
         magnets_ff <= magnets_in;
         min_rec_ff <= min_rec_in;
         window_ff  <= window_in;
      end
   end

   // a zero register stands for its reset value
   always_comb begin
      cfg.magnets = (magnets_ff == '0) ? pcdm_pkg::MAGNETS_DEFAULT : magnets_ff;
      cfg.need    = (min_rec_ff == '0) ? pcdm_pkg::MINREC_DEFAULT : min_rec_ff;
      cfg.window  = (window_ff == '0) ? pcdm_pkg::WINDOW_DEFAULT : window_ff;
   end

   assign req_full = q_stat.full;

   pcdm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_op        (req_op),
      .req_time_us   (req_time_us),
      .req_pin_level (req_pin_level),
      .q_stat        (q_stat),
      .cmd_push      (cmd_push),
      .cmd           (cmd_in_q)
   );

   pcdm_cmd_queue u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in_q),
      .pop   (cmd_pop),
      .dout  (cmd_out_q),
      .stat  (q_stat)
   );

   pcdm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_stat            (q_stat),
      .cmd               (cmd_out_q),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_rpm_x16       (rsp_rpm_x16),
      .rsp_forward       (rsp_forward),
      .rsp_cadence_valid (rsp_cadence_valid)
   );

endmodule

`default_nettype wire

// ===== tb/sv/pedal_cadence_direction_meter_core_tb.sv =====
// pedal_cadence_direction_meter_core_tb: self-checking bench for the cadence meter core
// depends on pcdm_pkg and pedal_cadence_direction_meter_core, and through it on the rest of rtl/core
`timescale 1ns / 1ps

module pedal_cadence_direction_meter_core_tb;

   // bench timing
   localparam int HOLD_CYCLES  = 1500;   // receiver hold-off that fills the core
   localparam int DRAIN_CYCLES = 300;    // edges still in flight after the last result
   localparam int QUIET_LIMIT  = 20000;  // cycles with no handshake before giving up

   // register index with no register behind it
   localparam logic [pcdm_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      pcdm_pkg::op_type            op;
      logic [pcdm_pkg::TIME_W-1:0] time_us;
      logic                        pin_level;
   } meter_word_type;

   typedef struct packed {
      logic [pcdm_pkg::RPM_W-1:0] rpm_x16;
      logic                       forward;
      logic                       cadence_valid;
   } cadence_type;

   // dut ports; the inputs driven by the bench are known from time zero
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic                           req_op = 1'b0;
   logic [pcdm_pkg::TIME_W-1:0]    req_time_us = '0;
   logic                           req_pin_level = 1'b0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [pcdm_pkg::RPM_W-1:0]     rsp_rpm_x16;
   logic                           rsp_forward;
   logic                           rsp_cadence_valid;
   logic                           csr_write_en = 1'b0;
   logic [pcdm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pcdm_pkg::CSR_W-1:0]     csr_wdata = '0;

   pedal_cadence_direction_meter_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_op            (req_op),
      .req_time_us       (req_time_us),
      .req_pin_level     (req_pin_level),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_rpm_x16       (rsp_rpm_x16),
      .rsp_forward       (rsp_forward),
      .rsp_cadence_valid (rsp_cadence_valid),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectations
   meter_word_type word_backlog[$];   // words waiting for the driver
   cadence_type    cadence_due[$];    // predicted cadence words, oldest first
   meter_word_type shown_word;        // word currently offered on req_*
   cadence_type    due_word;
   logic [pcdm_pkg::TIME_W-1:0] stamp_us = '0;  // timestamp cursor of the stimulus
   bit          calm = 1'b0;         // both sides stop idling while set

   // bookkeeping
   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned valid_seen   = 0;
   int unsigned edges_sent   = 0;
   int unsigned queries_sent = 0;
   int unsigned stall_cycles = 0;
   int unsigned settings     = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;
   int unsigned quiet_cycles = 0;

   // ---------------------------------------------------------------------
   // cadence predictor: own copy of the registers and of the record ring
   // ---------------------------------------------------------------------
   logic [pcdm_pkg::MAG_W-1:0]    cfg_magnets = pcdm_pkg::MAGNETS_DEFAULT;
   logic [pcdm_pkg::MINREC_W-1:0] cfg_need    = pcdm_pkg::MINREC_DEFAULT;
   logic [pcdm_pkg::TIME_W-1:0]   cfg_window  = pcdm_pkg::WINDOW_DEFAULT;

   logic [pcdm_pkg::TIME_W-1:0] last_edge_us = '0;
   logic [pcdm_pkg::TIME_W-1:0] low_hold_us  = '0;   // zero means no low time yet
   logic [pcdm_pkg::TIME_W-1:0] rec_stamp[pcdm_pkg::RING_DEPTH];
   logic [pcdm_pkg::TIME_W-1:0] rec_high[pcdm_pkg::RING_DEPTH];
   logic [pcdm_pkg::TIME_W-1:0] rec_low[pcdm_pkg::RING_DEPTH];
   int unsigned                 ring_wr   = 0;
   int unsigned                 rec_count = 0;

   // updates the model with one accepted word; a query adds one expected word
   function automatic void predict_cadence(input meter_word_type w);
      logic [pcdm_pkg::TIME_W-1:0]   dt, age, win_eff;
      logic [pcdm_pkg::MAG_W-1:0]    mags_eff;
      logic [pcdm_pkg::MINREC_W-1:0] need_eff;
      logic [pcdm_pkg::TIME_W-1:0]   kt[pcdm_pkg::RING_DEPTH];
      logic [pcdm_pkg::TIME_W-1:0]   kh[pcdm_pkg::RING_DEPTH];
      logic [pcdm_pkg::TIME_W-1:0]   kl[pcdm_pkg::RING_DEPTH];
      int unsigned                   kept, slot, fwd, bwd, i;
      longint unsigned               sum, divisor, rpm;
      cadence_type                   c;
      if (w.op == pcdm_pkg::OP_EDGE) begin
         dt = w.time_us - last_edge_us;
         last_edge_us = w.time_us;
         // glitches only move the last-edge time
         if (dt >= pcdm_pkg::GLITCH_US) begin
            if (w.pin_level) begin
               low_hold_us = dt;
            end else if (low_hold_us != 0) begin
               rec_stamp[ring_wr] = w.time_us;
               rec_high[ring_wr]  = dt;
               rec_low[ring_wr]   = low_hold_us;
               ring_wr = (ring_wr + 1) % pcdm_pkg::RING_DEPTH;
               if (rec_count < pcdm_pkg::RING_DEPTH) rec_count++;
            end
         end
      end else begin
         // zero in a register means its reset value
         mags_eff = (cfg_magnets != 0) ? cfg_magnets : pcdm_pkg::MAGNETS_DEFAULT;
         need_eff = (cfg_need != 0) ? cfg_need : pcdm_pkg::MINREC_DEFAULT;
         win_eff  = (cfg_window != 0) ? cfg_window : pcdm_pkg::WINDOW_DEFAULT;
         c = '0;
         // expire with a wrap-safe age, survivors packed from slot zero in order
         kept = 0;
         slot = (ring_wr + pcdm_pkg::RING_DEPTH - rec_count) % pcdm_pkg::RING_DEPTH;
         for (i = 0; i < rec_count; i++) begin
            age = w.time_us - rec_stamp[slot];
            if (age <= win_eff) begin
               kt[kept] = rec_stamp[slot];
               kh[kept] = rec_high[slot];
               kl[kept] = rec_low[slot];
               kept++;
            end
            slot = (slot + 1) % pcdm_pkg::RING_DEPTH;
         end
         for (i = 0; i < kept; i++) begin
            rec_stamp[i] = kt[i];
            rec_high[i]  = kh[i];
            rec_low[i]   = kl[i];
         end
         rec_count = kept;
         ring_wr   = kept % pcdm_pkg::RING_DEPTH;
         if (rec_count != 0 && rec_count >= need_eff) begin
            sum = 0;
            fwd = 0;
            bwd = 0;
            slot = (ring_wr + pcdm_pkg::RING_DEPTH - rec_count) % pcdm_pkg::RING_DEPTH;
            for (i = 0; i < rec_count; i++) begin
               sum = sum + 64'(rec_high[slot]) + 64'(rec_low[slot]);
               if (rec_high[slot] > rec_low[slot]) fwd++;
               else bwd++;
               slot = (slot + 1) % pcdm_pkg::RING_DEPTH;
            end
            // a tied vote leaves the word all zero
            if (fwd != bwd) begin
               divisor = (sum / rec_count) * mags_eff;
               rpm = 0;
               if (divisor != 0) begin
                  rpm = 64'(pcdm_pkg::RPM_NUM) / divisor;
                  if (rpm > 64'(pcdm_pkg::RPM_MAX)) rpm = 64'(pcdm_pkg::RPM_MAX);
               end
               c.rpm_x16       = rpm[pcdm_pkg::RPM_W-1:0];
               c.forward       = (fwd > bwd);
               c.cadence_valid = 1'b1;
            end
         end
         cadence_due.insert(cadence_due.size(), c);
      end
   endfunction

   // ---------------------------------------------------------------------
   // stimulus builders: every word moves the timestamp cursor by dt
   // ---------------------------------------------------------------------
   function automatic void queue_edge(input logic [pcdm_pkg::TIME_W-1:0] dt,
                                      input logic lvl);
      meter_word_type w;
      stamp_us    = stamp_us + dt;
      w.op        = pcdm_pkg::OP_EDGE;
      w.time_us   = stamp_us;
      w.pin_level = lvl;
      word_backlog.insert(word_backlog.size(), w);
   endfunction

   function automatic void queue_query(input logic [pcdm_pkg::TIME_W-1:0] dt);
      meter_word_type w;
      stamp_us    = stamp_us + dt;
      w.op        = pcdm_pkg::OP_QUERY;
      w.time_us   = stamp_us;
      w.pin_level = 1'($urandom_range(1));   // ignored by a query
      word_backlog.insert(word_backlog.size(), w);
   endfunction

   // mostly realistic half periods, some at the glitch edge, a few anything
   function automatic logic [pcdm_pkg::TIME_W-1:0] half_period();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return pcdm_pkg::GLITCH_US;
      if (pick < 80) return pcdm_pkg::TIME_W'($urandom_range(60000, 5000));
      if (pick < 95) return pcdm_pkg::TIME_W'($urandom_range(400000, 60000));
      return pcdm_pkg::TIME_W'($urandom);
   endfunction

   // short query gaps let a one-microsecond window keep the newest record
   function automatic logic [pcdm_pkg::TIME_W-1:0] query_gap();
      if ($urandom_range(99) < 30) return pcdm_pkg::TIME_W'($urandom_range(2));
      return pcdm_pkg::TIME_W'($urandom_range(1000));
   endfunction

   // mostly full pedal turns with queries between, the rest noise
   function automatic void queue_random_words(input int unsigned count);
      int unsigned made, pick;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            queue_edge(half_period(), 1'b1);
            queue_edge(half_period(), 1'b0);
            made += 2;
         end else if (pick < 85) begin
            queue_query(query_gap());
            made++;
         end else if (pick < 92) begin
            // glitch, ignored by the core, not counted
            queue_edge(pcdm_pkg::TIME_W'($urandom_range(pcdm_pkg::GLITCH_US - 1)),
                       1'($urandom_range(1)));
         end else if (pick < 97) begin
            // same level twice or a lone edge
            queue_edge(half_period(), 1'($urandom_range(1)));
            made++;
         end else if (pick < 99) begin
            // long jump, usually expires the whole ring
            queue_query(pcdm_pkg::TIME_W'($urandom));
            made++;
         end else begin
            queue_edge(pcdm_pkg::TIME_W'($urandom), 1'($urandom_range(1)));
            made++;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // register writes, only while the core is idle
   // ---------------------------------------------------------------------
   task automatic program_meter(input logic [pcdm_pkg::CSR_W-1:0] mag_w,
                                input logic [pcdm_pkg::CSR_W-1:0] need_w,
                                input logic [pcdm_pkg::CSR_W-1:0] win_w, input bit spare);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= pcdm_pkg::CSR_MAGNET_COUNT;
      csr_wdata    <= mag_w;
      @(posedge clock);
      csr_index    <= pcdm_pkg::CSR_MIN_RECORDS;
      csr_wdata    <= need_w;
      @(posedge clock);
      csr_index    <= pcdm_pkg::CSR_WINDOW_US;
      csr_wdata    <= win_w;
      @(posedge clock);
      if (spare) begin
         // index with no register, must change nothing
         csr_index <= CSR_SPARE_INDEX;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      cfg_magnets = mag_w[pcdm_pkg::MAG_W-1:0];
      cfg_need    = need_w[pcdm_pkg::MINREC_W-1:0];
      cfg_window  = win_w;
      settings++;
   endtask

   // all words in, all results out, then let trailing edges finish
   task automatic settle();
      while (word_backlog.size() != 0 || req_push || cadence_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: offers backlog words, predicts each one on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_cadence(shown_word);
            if (shown_word.op == pcdm_pkg::OP_QUERY) queries_sent++;
            else edges_sent++;
         end
         if (req_push && req_full) stall_cycles++;
         // a held word stays put until the core takes it
         if (!req_push || !req_full) begin
            if (word_backlog.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
               shown_word     = word_backlog[0];
               word_backlog.delete(0);
               req_push      <= 1'b1;
               req_op        <= shown_word.op;
               req_time_us   <= shown_word.time_us;
               req_pin_level <= shown_word.pin_level;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: pops result words and compares them with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (cadence_due.size() == 0) begin
               mismatches++;
               $error("result word with none expected: rpm_x16 %0d forward %0b valid %0b",
                      rsp_rpm_x16, rsp_forward, rsp_cadence_valid);
            end else begin
               due_word = cadence_due[0];
               cadence_due.delete(0);
               results_seen++;
               if (due_word.cadence_valid) valid_seen++;
               if (rsp_rpm_x16 !== due_word.rpm_x16) begin
                  mismatches++;
                  $error("rpm_x16: expected %0d actual %0d", due_word.rpm_x16, rsp_rpm_x16);
               end
               if (rsp_forward !== due_word.forward) begin
                  mismatches++;
                  $error("forward: expected %0b actual %0b", due_word.forward, rsp_forward);
               end
               if (rsp_cadence_valid !== due_word.cadence_valid) begin
                  mismatches++;
                  $error("cadence_valid: expected %0b actual %0b",
                         due_word.cadence_valid, rsp_cadence_valid);
               end
            end
         end
         // one long hold-off while plenty of words wait, so req_full must rise
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!hold_done && results_seen > 20 && word_backlog.size() > 100) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_pop  <= 1'b0;
         end else begin
            rsp_pop <= calm || ($urandom_range(99) >= 36);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset settings, cursor starts at zero
      queue_query(0);                 // empty ring at time zero
      queue_edge(20000, 1'b0);        // falling edge before any low time
      queue_edge(3000, 1'b1);         // glitch
      queue_edge(1999, 1'b1);         // glitch 1999 us after the last glitch
      queue_edge(5000, 1'b1);         // exactly the glitch limit, low time kept
      queue_edge(8000, 1'b0);         // first record, forward
      queue_query(1);                 // too few records
      queue_edge(12000, 1'b1);
      queue_edge(6000, 1'b0);         // backward record
      queue_query(1);                 // tied vote
      queue_edge(7000, 1'b1);
      queue_edge(9000, 1'b0);
      queue_query(1);                 // forward majority
      queue_edge(20000, 1'b1);
      queue_edge(5000, 1'b0);
      queue_edge(20000, 1'b1);
      queue_edge(5000, 1'b0);
      queue_edge(10000, 1'b1);
      queue_edge(10000, 1'b0);        // high equal to low votes backward
      queue_query(1);                 // backward majority
      queue_query(999999);            // newest record aged exactly the window
      queue_query(1);                 // one past the window, ring empties
      queue_edge(pcdm_pkg::TIME_W'(32'hFFFF_FFFF - stamp_us), 1'b1);  // edge at the top stamp
      queue_edge(6000, 1'b0);         // wraps past zero, huge low time
      queue_edge(7000, 1'b1);
      queue_edge(8000, 1'b0);
      queue_edge(5000, 1'b1);
      queue_edge(30000, 1'b0);
      queue_query(10);                // wrap-safe age, rpm truncates to zero
      queue_random_words(250);
      settle();

      // one magnet, single record enough, nothing ever expires; no idling
      program_meter(1, 1, 32'hFFFF_FFFF, 1'b0);
      calm = 1'b1;
      queue_random_words(300);
      settle();
      calm = 1'b0;

      // most magnets, a full ring needed
      program_meter(255, 16, 32'hFFFF_FFFF, 1'b0);
      queue_random_words(250);
      settle();

      // all registers zero, junk above the field widths, a write to no register
      program_meter($urandom & 32'hFFFF_FF00, $urandom & 32'hFFFF_FFE0, 0, 1'b1);
      queue_random_words(250);
      settle();

      // random settings inside the legal ranges
      program_meter($urandom_range(255, 1), $urandom_range(16, 1),
                    $urandom_range(3000000, 20000), 1'b0);
      queue_random_words(300);
      settle();

      // a minimum beyond the ring depth can never be met
      program_meter($urandom_range(255, 1), 31, $urandom, 1'b0);
      queue_random_words(150);
      settle();

      // one-microsecond window
      program_meter($urandom_range(255, 1), $urandom_range(4, 1), 1, 1'b0);
      queue_random_words(250);
      settle();

      // back to the reset values
      program_meter(pcdm_pkg::CSR_W'(pcdm_pkg::MAGNETS_DEFAULT),
                    pcdm_pkg::CSR_W'(pcdm_pkg::MINREC_DEFAULT),
                    pcdm_pkg::CSR_W'(pcdm_pkg::WINDOW_DEFAULT), 1'b0);
      queue_random_words(250);
      settle();

      $display("summary: %0d edge words and %0d queries under %0d register settings",
               edges_sent, queries_sent, settings + 1);
      $display("summary: %0d result words checked, %0d with a valid cadence, %0d full cycles",
               results_seen, valid_seen, stall_cycles);
      if (mismatches == 0 && cadence_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d predictions left over", mismatches, cadence_due.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
